/* hw/rtl/mvts_pkg.sv */
package mvts_pkg;

  // divider operand and result widths
  localparam int unsigned NUM_W = 58;
  localparam int unsigned DEN_W = 40;
  localparam int unsigned QUO_W = 16;

  // word codes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_TRIG = 1'b1;

  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SQUARE = 2'd1;
  localparam logic [1:0] WAVE_TRI    = 2'd2;
  localparam logic [1:0] WAVE_SAW    = 2'd3;

  localparam logic [1:0] DECAY_LIN  = 2'd1;
  localparam logic [1:0] DECAY_PARA = 2'd2;

  localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;

  // quarter-wave sine polynomial coefficients
  localparam logic [15:0] POLY_A = 16'd51472;
  localparam logic [15:0] POLY_B = 16'd21024;
  localparam logic [15:0] POLY_C = 16'd2320;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

/* hw/rtl/mvts_ram.sv */
module mvts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hw/rtl/mvts_div.sv */
module mvts_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mvts_pkg::div_req_t req_i,
  output mvts_pkg::div_rsp_t rsp_o
);

  import mvts_pkg::*;

  localparam int unsigned DSW = DEN_W + QUO_W - 1;
  localparam int unsigned CW  = $clog2(QUO_W);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [NUM_W-1:0] rem_q;
  logic [DSW-1:0]   dsh_q;
  logic [QUO_W-1:0] quo_q;
  logic             ge;

  assign ge = rem_q >= NUM_W'(dsh_q);

  // control: one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(QUO_W - 1);
    end else if (busy_q) begin
      busy_q <= (cnt_q != '0);
      done_q <= (cnt_q == '0);
      cnt_q  <= cnt_q - CW'(1);
    end else begin
      done_q <= 1'b0;
    end
  end

  // restoring shift-subtract datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num;
      dsh_q <= {req_i.den, {(QUO_W-1){1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - NUM_W'(dsh_q);
      end
      quo_q <= {quo_q[QUO_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

/* hw/rtl/multi_voice_tone_synthesizer_core.sv */
// trigger word: read, merge and write back of one tone entry
// tick word: accept, then read and check per mixed voice; each tone of an active voice
// goes through wave, level, advance and write back, plus a division for a decaying envelope
// (shared 16-step divider), then two mix divisions and the output
// one word at a time; a tick also waits out any output stall
// reset clears control, valid bits of the tone memory and sets voice count to 16
module multi_voice_tone_synthesizer_core #(
  parameter int unsigned MAX_VOICES      = 16,
  parameter int unsigned PHASE_BITS      = 24,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [3:0]         voice_i,
  input  logic               side_i,
  input  logic [1:0]         wave_i,
  input  logic [1:0]         decay_kind_i,
  input  logic [23:0]        phase_step_i,
  input  logic [15:0]        level_i,
  input  logic [19:0]        length_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] left_sample_o,
  output logic signed [15:0] right_sample_o
);

  import mvts_pkg::*;

  localparam int unsigned TONES = 2 * MAX_VOICES;
  localparam int unsigned AW    = $clog2(TONES);
  localparam int unsigned VCW   = $clog2(MAX_VOICES + 1);
  localparam int unsigned SW    = 17 + VCW;

  typedef struct packed {
    logic [1:0]            wave;
    logic [1:0]            decay;
    logic [23:0]           step;
    logic [15:0]           peak;
    logic [19:0]           len;
    logic [PHASE_BITS-1:0] phase;
    logic [15:0]           level;
    logic [19:0]           elapsed;
  } entry_t;

  localparam int unsigned EW = $bits(entry_t);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_TRD  = 5'd1;
  localparam logic [4:0] ST_TWR  = 5'd2;
  localparam logic [4:0] ST_RDL  = 5'd3;
  localparam logic [4:0] ST_RDR  = 5'd4;
  localparam logic [4:0] ST_CHK  = 5'd5;
  localparam logic [4:0] ST_WAV  = 5'd6;
  localparam logic [4:0] ST_SQ1  = 5'd7;
  localparam logic [4:0] ST_SQ2  = 5'd8;
  localparam logic [4:0] ST_SQ3  = 5'd9;
  localparam logic [4:0] ST_SQ4  = 5'd10;
  localparam logic [4:0] ST_LVL  = 5'd11;
  localparam logic [4:0] ST_ADV  = 5'd12;
  localparam logic [4:0] ST_LIN  = 5'd13;
  localparam logic [4:0] ST_PB1  = 5'd14;
  localparam logic [4:0] ST_PB2  = 5'd15;
  localparam logic [4:0] ST_PB3  = 5'd16;
  localparam logic [4:0] ST_DIVS = 5'd17;
  localparam logic [4:0] ST_DIVW = 5'd18;
  localparam logic [4:0] ST_WB   = 5'd19;
  localparam logic [4:0] ST_MXLS = 5'd20;
  localparam logic [4:0] ST_MXLW = 5'd21;
  localparam logic [4:0] ST_MXRS = 5'd22;
  localparam logic [4:0] ST_MXRW = 5'd23;
  localparam logic [4:0] ST_OUT  = 5'd24;

  logic [4:0]       state_q, state_d;
  logic [4:0]       voice_count_q;
  logic [VCW-1:0]   n_q, v_q, v_nxt, n_clamp;
  logic             side_q;
  logic [TONES-1:0] vld_q;
  logic             out_valid_q;
  logic [15:0]      left_q, right_q;

  logic             in_accept, out_free;
  logic             t_side;
  logic [3:0]       t_voice;
  logic [1:0]       t_wave, t_decay;
  logic [23:0]      t_step;
  logic [15:0]      t_level;
  logic [19:0]      t_len;
  logic [7:0]       t_idx;
  logic [AW-1:0]    t_addr;
  logic             t_ok;

  entry_t           ent_q [2];
  entry_t           cur, rent, merged;
  logic             rvld_q;
  logic [EW-1:0]    ram_rdata;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [EW-1:0]    ram_wdata;
  logic [VCW:0]     vs_l, vs_r, vs_w;

  logic [SW-1:0]    sum_q [2];
  logic [SW-1:0]    abs_l, abs_r;
  logic [15:0]      ql_q;
  logic [15:0]      x_q, x2_q, tmp_q, mag_q;
  logic             neg_q;
  logic [19:0]      t_q, dlt_q;
  logic [39:0]      prod_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;

  logic [39:0]      mul_a;
  logic [19:0]      mul_b;
  logic [59:0]      mul_p;

  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // wave decode signals
  logic [PHASE_BITS+31:0] pw;
  logic [31:0]            p32;
  logic [SINE_TABLE_BITS+16:0] sw;
  logic [16:0]            us, ut;
  logic [15:0]            xs, xt, sine_m, tv;
  logic [19:0]            t_new;
  logic [32:0]            phase_sum;
  logic [SW-1:0]          tv_ext;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // voice count clamp
  always_comb begin
    if (voice_count_q == 5'd0) begin
      n_clamp = VCW'(1);
    end else if (32'(voice_count_q) > 32'(MAX_VOICES)) begin
      n_clamp = VCW'(MAX_VOICES);
    end else begin
      n_clamp = VCW'(voice_count_q);
    end
  end

  // trigger address
  assign t_idx  = {3'b000, t_voice, t_side};
  assign t_addr = t_idx[AW-1:0];
  assign t_ok   = 32'(voice_i) < 32'(MAX_VOICES);
  assign v_nxt  = v_q + VCW'(1);
  assign vs_l   = {v_q, 1'b0};
  assign vs_r   = {v_q, 1'b1};
  assign vs_w   = {v_q, side_q};

  // tone memory with valid bits, unwritten entries read as zero
  assign rent = rvld_q ? entry_t'(ram_rdata) : '0;
  assign cur  = ent_q[side_q];

  always_comb begin
    merged         = rent;
    merged.wave    = t_wave;
    merged.decay   = t_decay;
    merged.step    = t_step;
    merged.peak    = t_level;
    merged.len     = t_len;
  end

  always_comb begin
    case (state_q)
      ST_TRD:  ram_raddr = t_addr;
      ST_RDR:  ram_raddr = vs_r[AW-1:0];
      default: ram_raddr = vs_l[AW-1:0];
    endcase
  end

  assign ram_we    = (state_q == ST_TWR) || (state_q == ST_WB);
  assign ram_waddr = (state_q == ST_TWR) ? t_addr : vs_w[AW-1:0];
  assign ram_wdata = (state_q == ST_TWR) ? EW'(merged) : EW'(cur);

  mvts_ram #(
    .WIDTH (EW),
    .DEPTH (TONES)
  ) u_tone_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // waveform decode from phase
  assign pw     = {cur.phase, 32'd0} >> PHASE_BITS;
  assign p32    = pw[31:0];
  assign sw     = {p32[31 -: SINE_TABLE_BITS], 17'd0} >> SINE_TABLE_BITS;
  assign us     = sw[16:0];
  assign ut     = p32[31:15];
  assign xs     = us[15] ? 16'(17'd32768 - {2'b00, us[14:0]}) : {1'b0, us[14:0]};
  assign xt     = ut[15] ? 16'(17'd32768 - {2'b00, ut[14:0]}) : {1'b0, ut[14:0]};
  assign sine_m = mul_p[30:15];
  assign tv     = mul_p[31:16];
  assign tv_ext = SW'(tv);
  assign t_new  = (cur.elapsed == ELAPSED_MAX) ? cur.elapsed : cur.elapsed + 20'd1;
  assign phase_sum = 33'(cur.phase) + 33'(cur.step);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ1: begin mul_a = 40'(x_q);     mul_b = 20'(x_q);    end
      ST_SQ2: begin mul_a = 40'(POLY_C);  mul_b = 20'(x2_q);   end
      ST_SQ3: begin mul_a = 40'(tmp_q);   mul_b = 20'(x2_q);   end
      ST_SQ4: begin mul_a = 40'(tmp_q);   mul_b = 20'(x_q);    end
      ST_LVL: begin mul_a = 40'(cur.level); mul_b = 20'(mag_q); end
      ST_LIN: begin mul_a = 40'(cur.peak); mul_b = dlt_q;      end
      ST_PB1: begin mul_a = 40'(t_q);     mul_b = dlt_q;       end
      ST_PB2: begin mul_a = prod_q;       mul_b = 20'(cur.peak); end
      ST_PB3: begin mul_a = 40'(cur.len); mul_b = cur.len;     end
      default: begin mul_a = '0;          mul_b = '0;          end
    endcase
  end

  assign mul_p = 60'(mul_a) * 60'(mul_b);

  // mix magnitudes and divider requests
  assign abs_l = sum_q[0][SW-1] ? (~sum_q[0] + SW'(1)) : sum_q[0];
  assign abs_r = sum_q[1][SW-1] ? (~sum_q[1] + SW'(1)) : sum_q[1];

  always_comb begin
    div_req.start = (state_q == ST_DIVS) || (state_q == ST_MXLS) || (state_q == ST_MXRS);
    case (state_q)
      ST_MXLS: begin div_req.num = NUM_W'(abs_l); div_req.den = DEN_W'(n_q); end
      ST_MXRS: begin div_req.num = NUM_W'(abs_r); div_req.den = DEN_W'(n_q); end
      default: begin div_req.num = num_q;         div_req.den = den_q;       end
    endcase
  end

  mvts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // signed result from magnitude quotient, saturated
  function automatic logic [15:0] mix_out(input logic neg, input logic [15:0] q);
    logic [15:0] r;
    if (!neg) begin
      r = q[15] ? 16'h7FFF : q;
    end else begin
      r = (q > 16'h8000) ? 16'h8000 : (~q + 16'd1);
    end
    return r;
  endfunction

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (mode_i == MODE_TICK) begin
            state_d = ST_RDL;
          end else if (t_ok) begin
            state_d = ST_TRD;
          end
        end
      end
      ST_TRD: state_d = ST_TWR;
      ST_TWR: state_d = ST_IDLE;
      ST_RDL: state_d = ST_RDR;
      ST_RDR: state_d = ST_CHK;
      ST_CHK: begin
        if (ent_q[0].peak == 16'd0 && rent.peak == 16'd0) begin
          state_d = (v_nxt == n_q) ? ST_MXLS : ST_RDL;
        end else begin
          state_d = ST_WAV;
        end
      end
      ST_WAV: state_d = (cur.wave == WAVE_SINE) ? ST_SQ1 : ST_LVL;
      ST_SQ1: state_d = ST_SQ2;
      ST_SQ2: state_d = ST_SQ3;
      ST_SQ3: state_d = ST_SQ4;
      ST_SQ4: state_d = ST_LVL;
      ST_LVL: state_d = ST_ADV;
      ST_ADV: begin
        if (t_new > cur.len) begin
          state_d = ST_WB;
        end else if (cur.decay == DECAY_LIN) begin
          state_d = ST_LIN;
        end else if (cur.decay == DECAY_PARA) begin
          state_d = ST_PB1;
        end else begin
          state_d = ST_WB;
        end
      end
      ST_LIN:  state_d = ST_DIVS;
      ST_PB1:  state_d = ST_PB2;
      ST_PB2:  state_d = ST_PB3;
      ST_PB3:  state_d = ST_DIVS;
      ST_DIVS: state_d = ST_DIVW;
      ST_DIVW: if (div_rsp.done) state_d = ST_WB;
      ST_WB: begin
        if (!side_q) begin
          state_d = ST_WAV;
        end else begin
          state_d = (v_nxt == n_q) ? ST_MXLS : ST_RDL;
        end
      end
      ST_MXLS: state_d = ST_MXLW;
      ST_MXLW: if (div_rsp.done) state_d = ST_MXRS;
      ST_MXRS: state_d = ST_MXRW;
      ST_MXRW: if (div_rsp.done) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      voice_count_q <= 5'd16;
      n_q           <= VCW'(1);
      v_q           <= '0;
      side_q        <= 1'b0;
      vld_q         <= '0;
      rvld_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rvld_q  <= vld_q[ram_raddr];
      if (cfg_we_i) begin
        voice_count_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (state_q == ST_IDLE && in_accept) begin
        n_q    <= n_clamp;
        v_q    <= '0;
        side_q <= 1'b0;
      end
      if (state_q == ST_CHK) begin
        side_q <= 1'b0;
        if (ent_q[0].peak == 16'd0 && rent.peak == 16'd0) begin
          v_q <= v_nxt;
        end
      end
      if (state_q == ST_WB) begin
        side_q <= 1'b1;
        if (side_q) begin
          v_q <= v_nxt;
        end
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          t_voice  <= voice_i;
          t_side   <= side_i;
          t_wave   <= wave_i;
          t_decay  <= decay_kind_i;
          t_step   <= phase_step_i;
          t_level  <= level_i;
          t_len    <= length_i;
          sum_q[0] <= '0;
          sum_q[1] <= '0;
        end
      end
      ST_RDR: ent_q[0] <= rent;
      ST_CHK: ent_q[1] <= rent;
      ST_WAV: begin
        case (cur.wave)
          WAVE_SINE: begin
            x_q   <= xs;
            neg_q <= us[16];
          end
          WAVE_SQUARE: begin
            mag_q <= 16'd16384;
            neg_q <= p32[31];
          end
          WAVE_TRI: begin
            mag_q <= (xt > 16'd32767) ? 16'd32767 : xt;
            neg_q <= ut[16];
          end
          default: begin
            if (p32[31]) begin
              mag_q <= {1'b0, p32[30:16]};
              neg_q <= 1'b0;
            end else begin
              mag_q <= 16'(17'd32768 - {1'b0, p32[31:16]});
              neg_q <= 1'b1;
            end
          end
        endcase
      end
      ST_SQ1: x2_q  <= mul_p[30:15];
      ST_SQ2: tmp_q <= POLY_B - mul_p[30:15];
      ST_SQ3: tmp_q <= POLY_A - mul_p[30:15];
      ST_SQ4: mag_q <= (sine_m > 16'd32767) ? 16'd32767 : sine_m;
      ST_LVL: sum_q[side_q] <= neg_q ? (sum_q[side_q] - tv_ext) : (sum_q[side_q] + tv_ext);
      ST_ADV: begin
        t_q   <= t_new;
        dlt_q <= cur.len - t_new;
        ent_q[side_q].phase <= phase_sum[PHASE_BITS-1:0];
        if (t_new > cur.len) begin
          ent_q[side_q].peak    <= 16'd0;
          ent_q[side_q].level   <= 16'd0;
          ent_q[side_q].elapsed <= 20'd0;
        end else begin
          ent_q[side_q].elapsed <= t_new;
          ent_q[side_q].level   <= cur.peak;
        end
      end
      ST_LIN: begin
        num_q <= NUM_W'(mul_p[35:0]);
        den_q <= DEN_W'(cur.len);
      end
      ST_PB1: prod_q <= mul_p[39:0];
      ST_PB2: num_q  <= {mul_p[55:0], 2'b00};
      ST_PB3: den_q  <= mul_p[39:0];
      ST_DIVW: if (div_rsp.done) ent_q[side_q].level <= div_rsp.quo;
      ST_MXLW: if (div_rsp.done) ql_q <= div_rsp.quo;
      ST_OUT: begin
        if (out_free) begin
          left_q  <= mix_out(sum_q[0][SW-1], ql_q);
          right_q <= mix_out(sum_q[1][SW-1], div_rsp.quo);
        end
      end
      default: ;
    endcase
    if (state_q == ST_MXRW && div_rsp.done) begin
      x2_q <= div_rsp.quo;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = left_q;
  assign right_sample_o = right_q;

  // checks on sequencer, divider, tone memory and output interplay
  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIVW || state_q == ST_MXLW || state_q == ST_MXRW))
    else $error("divider result with nobody waiting");

  a_ram_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_TWR || state_q == ST_WB))
    else $error("tone memory written outside write-back");

  a_voice_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RDL) |-> (v_q < n_q))
    else $error("voice walk beyond voice count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && out_stall_i) |=> (state_q == ST_OUT && out_valid_q))
    else $error("pending sample lost while output stalled");

endmodule
